@@ hw/rtl/integer_to_ascii_formatter_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the integer to ASCII formatter.
// Every macro expects clk and rst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ITOA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define ITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/itoa_pkg.sv @@
// ----------------------------------------------------------------------------
// itoa_pkg
// Types, constants and the digit character function of the integer to ASCII
// formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    // Default cap on digits plus padding.
    localparam int MAX_CHARS_DEF = 64;

    // Width of the compare between field width and character counts.
    localparam int CMP_W = 7;

    // Operand width and the bit counter of the serial divider.
    localparam int VAL_W = 64;
    localparam int BIT_W = 6;

    // Base limits.
    localparam logic [4:0] BASE_MIN = 5'd2;
    localparam logic [4:0] BASE_MAX = 5'd16;
    localparam logic [4:0] BASE_DEC = 5'd10;

    // Fixed characters.
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_UPPER = 8'h41;
    localparam logic [7:0] CHAR_LOWER = 8'h61;

    // Input word: one number to format.
    typedef struct packed {
        logic [63:0] value;
        logic        signed_mode;
        logic [4:0]  base;
        logic [5:0]  width;
        logic [7:0]  pad_char;
        logic        uppercase;
    } in_word_t;

    // Output word: one character.
    typedef struct packed {
        logic [7:0] char_out;
        logic       last;
    } out_word_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_SIGN,
        ST_PAD,
        ST_DIGIT
    } state_t;

    // Maps a digit from 0 to 15 onto its ASCII character.
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
        logic [7:0] res;
        if (d < 4'd10)
        begin
            res = CHAR_ZERO + {4'b0000, d};
        end
        else
        begin
            res = (up ? CHAR_UPPER : CHAR_LOWER) + {4'b0000, d} - 8'd10;
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/integer_to_ascii_formatter_core.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Formats a 64-bit integer in a base from 2 to 16 as ASCII characters, most
// significant first, with a minimum field width and a pad character.
// ----------------------------------------------------------------------------
//
//  channel | signals                       | word type  | moves
//  --------+-------------------------------+------------+---------------------
//  num     | num_valid, num_stall, num     | in_word_t  | one number to format
//  chr     | chr_valid, chr_stall, chr     | out_word_t | one output character
//
//  Each digit comes from a pass of a restoring bit-serial divider and a test of
//  the quotient; after the last digit, characters leave at one per cycle while
//  the output is not stalled.
//  A decimal 64-bit number needs up to 20 digits.
//  A number with a base outside 2 to 16 is taken and gives nothing.
//  num_stall is high from the cycle after acceptance until the last character
//  has entered the output register; chr_stall holds the output register.
//  Reset clears the sequencer, the counters and the output valid.
//
module integer_to_ascii_formatter_core #(
    parameter int MAX_CHARS = itoa_pkg::MAX_CHARS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                num_valid,
    output logic                num_stall,
    input  itoa_pkg::in_word_t  num,
    output logic                chr_valid,
    input  logic                chr_stall,
    output itoa_pkg::out_word_t chr
);

    localparam int NW = $clog2(MAX_CHARS + 1);
    localparam int CW = itoa_pkg::CMP_W;
    localparam int VW = itoa_pkg::VAL_W;
    localparam int BW = itoa_pkg::BIT_W;

    itoa_pkg::state_t state_reg, state_next;

    logic [VW-1:0]   mag_reg;
    logic [3:0]      rem_reg;
    logic [BW-1:0]   bit_reg;
    logic [NW-1:0]   ndig_reg;
    logic [NW-1:0]   pad_reg;
    logic            neg_reg;
    logic            upper_reg;
    logic [4:0]      base_reg;
    logic [5:0]      width_reg;
    logic [7:0]      padch_reg;
    logic [3:0]      stack_reg [MAX_CHARS];
    logic                out_valid_reg;
    itoa_pkg::out_word_t out_word_reg;

    logic            accept;
    logic            base_ok;
    logic            load;
    logic            in_neg;
    logic [4:0]      rem_sh;
    logic            ge;
    logic [3:0]      rem_new;
    logic [VW-1:0]   mag_new;
    logic            last_bit;
    logic            more_digits;
    logic [CW-1:0]   lim;
    logic [CW-1:0]   ndig_ext;
    logic [NW-1:0]   pad_calc;
    logic            emit;
    itoa_pkg::out_word_t emit_word;

    // Handshake terms.
    assign num_stall = (state_reg != itoa_pkg::ST_IDLE);
    assign accept    = num_valid && !num_stall;
    assign base_ok   = (num.base >= itoa_pkg::BASE_MIN) && (num.base <= itoa_pkg::BASE_MAX);
    assign load      = !out_valid_reg || !chr_stall;
    assign in_neg    = num.signed_mode && (num.base == itoa_pkg::BASE_DEC) && num.value[VW-1];

    // One step of the restoring divider: the quotient bit shifts in at the bottom.
    assign rem_sh   = {rem_reg, mag_reg[VW-1]};
    assign ge       = (rem_sh >= base_reg);
    assign rem_new  = ge ? 4'(rem_sh - base_reg) : rem_sh[3:0];
    assign mag_new  = {mag_reg[VW-2:0], ge};
    assign last_bit = (bit_reg == BW'(VW - 1));

    // Another digit is needed while the quotient is nonzero and the cap allows.
    assign more_digits = (mag_reg != '0) && (ndig_reg != NW'(MAX_CHARS));

    // Padding fills up to the width, itself capped at MAX_CHARS.
    assign lim      = ({1'b0, width_reg} > CW'(MAX_CHARS)) ? CW'(MAX_CHARS) : {1'b0, width_reg};
    assign ndig_ext = CW'(ndig_reg);
    assign pad_calc = (lim > ndig_ext) ? NW'(lim - ndig_ext) : '0;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            itoa_pkg::ST_IDLE:
            begin
                if (accept && base_ok)
                begin
                    state_next = itoa_pkg::ST_DIV;
                end
            end
            itoa_pkg::ST_DIV:
            begin
                if (last_bit)
                begin
                    state_next = itoa_pkg::ST_CHECK;
                end
            end
            itoa_pkg::ST_CHECK:
            begin
                if (more_digits)
                begin
                    state_next = itoa_pkg::ST_DIV;
                end
                else if (neg_reg)
                begin
                    state_next = itoa_pkg::ST_SIGN;
                end
                else if (pad_calc != '0)
                begin
                    state_next = itoa_pkg::ST_PAD;
                end
                else
                begin
                    state_next = itoa_pkg::ST_DIGIT;
                end
            end
            itoa_pkg::ST_SIGN:
            begin
                if (load)
                begin
                    state_next = (pad_reg != '0) ? itoa_pkg::ST_PAD : itoa_pkg::ST_DIGIT;
                end
            end
            itoa_pkg::ST_PAD:
            begin
                if (load && (pad_reg == NW'(1)))
                begin
                    state_next = itoa_pkg::ST_DIGIT;
                end
            end
            itoa_pkg::ST_DIGIT:
            begin
                if (load && (ndig_reg == NW'(1)))
                begin
                    state_next = itoa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = itoa_pkg::ST_IDLE;
            end
        endcase
    end

    // Character offered to the output register in each state.
    always_comb
    begin
        emit               = 1'b0;
        emit_word.char_out = itoa_pkg::CHAR_MINUS;
        emit_word.last     = 1'b0;
        case (state_reg)
            itoa_pkg::ST_SIGN:
            begin
                emit = 1'b1;
            end
            itoa_pkg::ST_PAD:
            begin
                emit               = 1'b1;
                emit_word.char_out = padch_reg;
            end
            itoa_pkg::ST_DIGIT:
            begin
                emit               = 1'b1;
                emit_word.char_out = itoa_pkg::digit_char(stack_reg[0], upper_reg);
                emit_word.last     = (ndig_reg == NW'(1));
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= itoa_pkg::ST_IDLE;
            bit_reg       <= '0;
            ndig_reg      <= '0;
            pad_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                bit_reg  <= '0;
                ndig_reg <= '0;
            end
            if (state_reg == itoa_pkg::ST_DIV)
            begin
                bit_reg <= bit_reg + BW'(1);
                if (last_bit)
                begin
                    ndig_reg <= ndig_reg + NW'(1);
                end
            end
            if (state_reg == itoa_pkg::ST_CHECK)
            begin
                pad_reg <= pad_calc;
            end
            if ((state_reg == itoa_pkg::ST_PAD) && load)
            begin
                pad_reg <= pad_reg - NW'(1);
            end
            if ((state_reg == itoa_pkg::ST_DIGIT) && load)
            begin
                ndig_reg <= ndig_reg - NW'(1);
            end
            if (load)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    // Operand, divider and digit stack; pushed least significant first.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_reg   <= in_neg ? (~num.value + VW'(1)) : num.value;
            rem_reg   <= '0;
            neg_reg   <= in_neg;
            upper_reg <= num.uppercase && !num.signed_mode;
            base_reg  <= num.base;
            width_reg <= (in_neg && (num.width != '0)) ? (num.width - 6'd1) : num.width;
            padch_reg <= num.pad_char;
        end
        if (state_reg == itoa_pkg::ST_DIV)
        begin
            mag_reg <= mag_new;
            rem_reg <= last_bit ? 4'd0 : rem_new;
            if (last_bit)
            begin
                stack_reg[0] <= rem_new;
                for (int i = 1; i < MAX_CHARS; i++)
                begin
                    stack_reg[i] <= stack_reg[i-1];
                end
            end
        end
        if ((state_reg == itoa_pkg::ST_DIGIT) && load)
        begin
            for (int i = 0; i < MAX_CHARS - 1; i++)
            begin
                stack_reg[i] <= stack_reg[i+1];
            end
        end
        if (load)
        begin
            out_word_reg <= emit_word;
        end
    end

    assign chr_valid = out_valid_reg;
    assign chr       = out_word_reg;

    // Checks on the sequencer and counters.
`include "integer_to_ascii_formatter_core_macros.svh"

    `ITOA_ASSERT(a_ndig_cap, CW'(ndig_reg) <= CW'(MAX_CHARS), "digit count beyond cap")
    `ITOA_ASSERT(a_idle_empty, !accept || (ndig_reg == '0), "number taken with digits pending")
    `ITOA_ASSERT(a_pad_nonzero, (state_reg != itoa_pkg::ST_PAD) || (pad_reg != '0), "pad state with no padding")
    `ITOA_ASSERT_NEXT(a_last_end, (state_reg == itoa_pkg::ST_DIGIT) && load && (ndig_reg == NW'(1)), chr_valid && chr.last && (state_reg == itoa_pkg::ST_IDLE), "final digit not marked last")

endmodule
